@@ hdl/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the table linear interpolator
// Field widths, payload structs, state encodings and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  // default table size
  localparam int TABLE_DEPTH_DEF = 1024;

  // field widths
  localparam int VAL_W    = 48;
  localparam int IDX_IN_W = 10;
  localparam int CNT_IN_W = 11;

  // arithmetic widths: key/value differences, exact product, quotient
  localparam int DIFF_W    = VAL_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int HALF_W    = (DIFF_W + 1) / 2;
  localparam int PP_W      = 2 * HALF_W;
  localparam int MUL_STEPS = 4;
  localparam int QBITS     = 50;
  localparam int Q_W       = QBITS + 1;
  localparam int QCNT_W    = $clog2(QBITS);
  localparam int RES_W     = Q_W + 1;

  // entry count limits and reset value
  localparam int                  MIN_ENTRIES     = 2;
  localparam logic [CNT_IN_W-1:0] ENTRY_COUNT_RST = CNT_IN_W'(MIN_ENTRIES);

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [IDX_IN_W-1:0] entry_index;
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;
  } tli_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    in_range;
  } tli_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_SEARCH,
    ST_GET_LO,
    ST_GET_HI,
    ST_START,
    ST_CALC,
    ST_FIN,
    ST_OOR
  } ctrl_state_t;

  typedef enum logic [2:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID,
    RD_LO,
    RD_LO1
  } rd_sel_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_ACC,
    MD_CHECK,
    MD_DIV,
    MD_DONE
  } md_phase_t;

  typedef struct packed {
    logic    wr_en;
    logic    start_query;
    rd_sel_t rd_sel;
    logic    step;
    logic    load_lo;
    logic    load_diff;
    logic    md_start;
    logic    out_load;
    logic    out_hit;
  } tli_cmd_t;

  typedef struct packed {
    logic x_lt_key;
    logic x_gt_key;
    logic more;
    logic md_done;
  } tli_status_t;

endpackage

`default_nettype wire

@@ hdl/tli_muldiv.sv @@
// ----------------------------------------------------------------------------
// tli_muldiv: sequential multiply then divide with clamped quotient
// Forms a*b exactly from four partial products of one 25x25 multiplier,
// then restoring division by d one quotient bit per cycle; quotient >= 2^50
// clamps to 2^50.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_muldiv (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tli_pkg::DIFF_W-1:0] a,
  input  wire logic [tli_pkg::DIFF_W-1:0] b,
  input  wire logic [tli_pkg::DIFF_W-1:0] d,
  output logic                            done,
  output logic [tli_pkg::Q_W-1:0]         q
);

  localparam int DW = tli_pkg::DIFF_W;
  localparam int HW = tli_pkg::HALF_W;
  localparam int PW = tli_pkg::PROD_W;
  localparam int QB = tli_pkg::QBITS;

  tli_pkg::md_phase_t phase_r, phase_nxt;
  logic [tli_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pp_v_r;

  logic [DW-1:0]            a_r, b_r, d_r;
  logic [PW-1:0]            prod_r;
  logic [tli_pkg::PP_W-1:0] pp_r;
  logic [1:0]               pp_sh_r;
  logic [DW-1:0]            rem_r;
  logic [QB-1:0]            shf_r;
  logic                     sat_r;

  logic [HW-1:0] a_sel, b_sel;
  logic [PW-1:0] pp_ext;
  logic          sat_now;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;

  // operand halves picked by the beat counter
  assign a_sel = cnt_r[1] ? HW'(a_r[DW-1:HW]) : a_r[HW-1:0];
  assign b_sel = cnt_r[0] ? HW'(b_r[DW-1:HW]) : b_r[HW-1:0];

  // partial product aligned to its weight
  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_ext = PW'(pp_r);
      2'd1:    pp_ext = PW'(pp_r) << HW;
      default: pp_ext = PW'(pp_r) << (2 * HW);
    endcase
  end

  // quotient would reach 2^50: product at least d shifted by 50
  assign sat_now = {1'b0, prod_r} >= {d_r, {QB{1'b0}}};

  // one restoring division step
  assign rem_sh = {rem_r, shf_r[QB-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, d_r};

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r) inside
      tli_pkg::MD_IDLE, tli_pkg::MD_DONE: begin
        if (start) begin
          phase_nxt = tli_pkg::MD_MUL;
          cnt_nxt   = '0;
        end
      end
      tli_pkg::MD_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tli_pkg::QCNT_W'(tli_pkg::MUL_STEPS - 1)) begin
          phase_nxt = tli_pkg::MD_ACC;
        end
      end
      tli_pkg::MD_ACC: begin
        phase_nxt = tli_pkg::MD_CHECK;
      end
      tli_pkg::MD_CHECK: begin
        cnt_nxt   = '0;
        phase_nxt = sat_now ? tli_pkg::MD_DONE : tli_pkg::MD_DIV;
      end
      tli_pkg::MD_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tli_pkg::QCNT_W'(QB - 1)) begin
          phase_nxt = tli_pkg::MD_DONE;
        end
      end
      default: begin
        phase_nxt = tli_pkg::MD_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tli_pkg::MD_IDLE;
      cnt_r   <= '0;
      pp_v_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pp_v_r  <= (phase_r == tli_pkg::MD_MUL);
    end
  end

  // operands, product accumulation and divider registers
  always_ff @(posedge clk) begin
    pp_r    <= a_sel * b_sel;
    pp_sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      d_r    <= d;
      prod_r <= '0;
    end else if (pp_v_r) begin
      prod_r <= prod_r + pp_ext;
    end
    if (phase_r == tli_pkg::MD_CHECK) begin
      sat_r <= sat_now;
      rem_r <= DW'(prod_r[PW-1:QB]);
      shf_r <= prod_r[QB-1:0];
    end else if (phase_r == tli_pkg::MD_DIV) begin
      rem_r <= diff[DW+1] ? rem_sh[DW-1:0] : diff[DW-1:0];
      shf_r <= {shf_r[QB-2:0], ~diff[DW+1]};
    end
  end

  assign done = (phase_r == tli_pkg::MD_DONE);
  assign q    = sat_r ? {1'b1, {QB{1'b0}}} : {1'b0, shf_r};

`ifndef SYNTHESIS
  // partial remainder stays below the divisor throughout the divide
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tli_pkg::MD_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ hdl/tli_datapath.sv @@
// ----------------------------------------------------------------------------
// tli_datapath: table memories, bisection bounds and interpolation math
// Holds key and value tables, the entry count register, the search bounds,
// the bracketing pair and the result register; runs the multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_datapath #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tli_pkg::tli_in_t             in_data,
  input  wire logic                         cfg_we,
  input  wire logic [tli_pkg::CNT_IN_W-1:0] cfg_data,
  input  wire tli_pkg::tli_cmd_t            cmd,
  output tli_pkg::tli_status_t              status,
  output tli_pkg::tli_out_t                 out_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int VW    = tli_pkg::VAL_W;
  localparam int DW    = tli_pkg::DIFF_W;
  localparam int RW    = tli_pkg::RES_W;

  logic [VW-1:0] key_mem [TABLE_DEPTH];
  logic [VW-1:0] val_mem [TABLE_DEPTH];

  logic [tli_pkg::CNT_IN_W-1:0] entry_count_r;
  logic signed [VW-1:0]         x_r;
  logic [IDX_W-1:0]             last_r, lo_r, hi_r;
  logic signed [VW-1:0]         key_rd_r, val_rd_r;
  logic signed [VW-1:0]         klo_r, ylo_r;
  logic [DW-1:0]                mag_dx_r, mag_dy_r, mag_dq_r;
  logic                         neg_r, dx_zero_r;
  tli_pkg::tli_out_t            out_r;

  logic [31:0]      cnt_ext, n_clamp, wr_idx;
  logic [IDX_W-1:0] last_calc, lo_nxt, hi_nxt, span_nxt, mid_nxt, rd_addr;
  logic [IDX_W:0]   mid_sum;
  logic             wr_ok;
  logic [DW-1:0]    dx, dy, dq, mag_dx, mag_dy, mag_dq;
  logic             md_done;
  logic [tli_pkg::Q_W-1:0] md_q, q_eff;
  logic [RW-1:0]    y_ext, sum;
  logic signed [VW-1:0] res_sat;

  // active entry count clamped to the table
  always_comb begin
    cnt_ext = 32'(entry_count_r);
    if (cnt_ext < 32'(tli_pkg::MIN_ENTRIES)) begin
      n_clamp = 32'(tli_pkg::MIN_ENTRIES);
    end else if (cnt_ext > 32'(TABLE_DEPTH)) begin
      n_clamp = 32'(TABLE_DEPTH);
    end else begin
      n_clamp = cnt_ext;
    end
    last_calc = IDX_W'(n_clamp - 32'd1);
  end

  // bisection bounds after this cycle's step
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.step) begin
      if (x_r > key_rd_r) begin
        lo_nxt = mid_sum[IDX_W:1];
      end else begin
        hi_nxt = mid_sum[IDX_W:1];
      end
    end
  end

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign span_nxt = hi_nxt - lo_nxt;
  assign mid_nxt  = IDX_W'(({1'b0, lo_nxt} + {1'b0, hi_nxt}) >> 1);

  // table read address
  always_comb begin
    unique case (cmd.rd_sel)
      tli_pkg::RD_FIRST: rd_addr = '0;
      tli_pkg::RD_LAST:  rd_addr = last_r;
      tli_pkg::RD_MID:   rd_addr = mid_nxt;
      tli_pkg::RD_LO:    rd_addr = lo_nxt;
      tli_pkg::RD_LO1:   rd_addr = lo_r + 1'b1;
      default:           rd_addr = '0;
    endcase
  end

  // writes beyond the table are dropped
  assign wr_idx = 32'(in_data.entry_index);
  assign wr_ok  = cmd.wr_en && (wr_idx < 32'(TABLE_DEPTH));

  // table memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      key_mem[wr_idx[IDX_W-1:0]] <= in_data.x_value;
      val_mem[wr_idx[IDX_W-1:0]] <= in_data.y_value;
    end
    key_rd_r <= key_mem[rd_addr];
    val_rd_r <= val_mem[rd_addr];
  end

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= tli_pkg::ENTRY_COUNT_RST;
    end else if (cfg_we) begin
      entry_count_r <= cfg_data;
    end
  end

  // differences and magnitudes over the bracketing interval
  assign dx     = {key_rd_r[VW-1], key_rd_r} - {klo_r[VW-1], klo_r};
  assign dy     = {val_rd_r[VW-1], val_rd_r} - {ylo_r[VW-1], ylo_r};
  assign dq     = {x_r[VW-1], x_r} - {klo_r[VW-1], klo_r};
  assign mag_dx = dx[DW-1] ? (DW'(0) - dx) : dx;
  assign mag_dy = dy[DW-1] ? (DW'(0) - dy) : dy;
  assign mag_dq = dq[DW-1] ? (DW'(0) - dq) : dq;

  // query, search and operand registers
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      x_r    <= in_data.x_value;
      last_r <= last_calc;
      lo_r   <= '0;
      hi_r   <= last_calc;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.load_lo) begin
      klo_r <= key_rd_r;
      ylo_r <= val_rd_r;
    end
    if (cmd.load_diff) begin
      mag_dx_r  <= mag_dx;
      mag_dy_r  <= mag_dy;
      mag_dq_r  <= mag_dq;
      neg_r     <= dx[DW-1] ^ dy[DW-1] ^ dq[DW-1];
      dx_zero_r <= (dx == '0);
    end
  end

  tli_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.md_start),
    .a     (mag_dy_r),
    .b     (mag_dq_r),
    .d     (mag_dx_r),
    .done  (md_done),
    .q     (md_q)
  );

  // y[lo] plus or minus the quotient, saturated to 48 bits
  always_comb begin
    q_eff = dx_zero_r ? '0 : md_q;
    y_ext = {{(RW - VW){ylo_r[VW-1]}}, ylo_r};
    sum   = neg_r ? (y_ext - {1'b0, q_eff}) : (y_ext + {1'b0, q_eff});
    if (sum[RW-1:VW-1] == '0 || sum[RW-1:VW-1] == '1) begin
      res_sat = sum[VW-1:0];
    end else if (sum[RW-1]) begin
      res_sat = {1'b1, {(VW - 1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(VW - 1){1'b1}}};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.result_value <= cmd.out_hit ? res_sat : '0;
      out_r.in_range     <= cmd.out_hit;
    end
  end

  assign out_data        = out_r;
  assign status.x_lt_key = (x_r < key_rd_r);
  assign status.x_gt_key = (x_r > key_rd_r);
  assign status.more     = (span_nxt > IDX_W'(1));
  assign status.md_done  = md_done;

`ifndef SYNTHESIS
  // bisection only steps while lo is below hi
  a_step_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (lo_r < hi_r))
    else $error("bisection step on a collapsed interval");

  // the upper neighbor of the bracket lies within the active entries
  a_lo_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_lo |-> (lo_r < last_r))
    else $error("bracket start at the last active entry");
`endif

endmodule

`default_nettype wire

@@ hdl/tli_ctrl.sv @@
// ----------------------------------------------------------------------------
// tli_ctrl: sequencer for writes, range checks, bisection and division
// Accepts items in idle, walks one query through the datapath and hands the
// result to the output register, which it holds while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_kind,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire tli_pkg::tli_status_t status,
  output tli_pkg::tli_cmd_t         cmd
);

  tli_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign in_ready = (state_r == tli_pkg::ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = tli_pkg::RD_FIRST;
    unique case (state_r)
      tli_pkg::ST_IDLE: begin
        if (in_valid && in_kind == tli_pkg::KIND_QUERY) begin
          cmd.start_query = 1'b1;
          state_nxt       = tli_pkg::ST_CHK_LO;
        end else if (in_valid) begin
          cmd.wr_en = 1'b1;
        end
      end
      tli_pkg::ST_CHK_LO: begin
        cmd.rd_sel = tli_pkg::RD_LAST;
        state_nxt  = status.x_lt_key ? tli_pkg::ST_OOR : tli_pkg::ST_CHK_HI;
      end
      tli_pkg::ST_CHK_HI: begin
        if (status.x_gt_key) begin
          state_nxt = tli_pkg::ST_OOR;
        end else if (status.more) begin
          cmd.rd_sel = tli_pkg::RD_MID;
          state_nxt  = tli_pkg::ST_SEARCH;
        end else begin
          cmd.rd_sel = tli_pkg::RD_LO;
          state_nxt  = tli_pkg::ST_GET_LO;
        end
      end
      tli_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.more) begin
          cmd.rd_sel = tli_pkg::RD_MID;
        end else begin
          cmd.rd_sel = tli_pkg::RD_LO;
          state_nxt  = tli_pkg::ST_GET_LO;
        end
      end
      tli_pkg::ST_GET_LO: begin
        cmd.load_lo = 1'b1;
        cmd.rd_sel  = tli_pkg::RD_LO1;
        state_nxt   = tli_pkg::ST_GET_HI;
      end
      tli_pkg::ST_GET_HI: begin
        cmd.load_diff = 1'b1;
        state_nxt     = tli_pkg::ST_START;
      end
      tli_pkg::ST_START: begin
        cmd.md_start = 1'b1;
        state_nxt    = tli_pkg::ST_CALC;
      end
      tli_pkg::ST_CALC: begin
        if (status.md_done) begin
          state_nxt = tli_pkg::ST_FIN;
        end
      end
      tli_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_hit  = 1'b1;
          state_nxt    = tli_pkg::ST_IDLE;
        end
      end
      tli_pkg::ST_OOR: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tli_pkg::ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the beat is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tli_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // a result appears only from the finish or out-of-range step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tli_pkg::ST_FIN || state_r == tli_pkg::ST_OOR))
    else $error("result raised outside a finishing step");

  // an accepted query starts with the lower range check
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == tli_pkg::KIND_QUERY) |=> (state_r == tli_pkg::ST_CHK_LO))
    else $error("query accepted without starting the range check");
`endif

endmodule

`default_nettype wire

@@ hdl/table_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise linear lookup over a key/value table
// Input beats either write one (key, value) entry or query an abscissa; each
// query returns one beat with the interpolated Q24.24 value and in_range.
//
// Channels: in_* (valid/ready, tli_in_t), out_* (valid/ready, tli_out_t),
// cfg_* (valid/ready, entry count, always ready).
// Writes are taken one per cycle while idle and give no result. A query walks a
// controller through: two range reads, one bisection read per cycle, two
// bracket reads, a four-step 25x25 multiply and a one-bit-per-cycle divide
// of 50 steps. The divide dominates an in-range query, and a saturating
// quotient skips it. Out-of-range queries end right after the range checks.
// One query is in flight at a time; input ready is high only when idle.
// The result register holds its beat while out_ready is low; a new item is
// still taken meanwhile, and the next query waits at its end for the slot.
// Reset clears control state and sets entry_count to 2; the tables are not
// cleared, so an entry must be written before a query reaches it.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire tli_pkg::tli_in_t             in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output tli_pkg::tli_out_t                 out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tli_pkg::CNT_IN_W-1:0] cfg_data
);

  tli_pkg::tli_cmd_t    cmd;
  tli_pkg::tli_status_t status;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
